// ----- sv/vgrt_pkg.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// vgrt_pkg
// Shared types, constants and fixed-point helpers for the voxel ray core.
// ---------------------------------------------------------------------------
package vgrt_pkg;

   typedef logic signed [63:0] wide_type;

   localparam logic [1:0] FUNC_WRITE   = 2'd0;
   localparam logic [1:0] FUNC_NEAREST = 2'd1;
   localparam logic [1:0] FUNC_OCCLUDE = 2'd2;

   localparam logic [1:0] AXIS_X = 2'd0;
   localparam logic [1:0] AXIS_Y = 2'd1;
   localparam logic [1:0] AXIS_Z = 2'd2;

   localparam int       FRAC_BITS   = 24;
   localparam wide_type ONE_Q       = 64'sd16777216;
   localparam wide_type RAY_NUDGE   = 64'sd1678;
   localparam wide_type SETUP_NUDGE = 64'sd839;
   localparam wide_type T_INF       = 64'sh4000_0000_0000_0000;
   localparam wide_type TD_NUM      = 64'sh0001_0000_0000_0000;
   localparam logic [31:0] MISS_DIST = 32'h7FFF_FFFF;

   typedef struct packed {
      logic [1:0]         func;
      logic [5:0]         voxel_x;
      logic [5:0]         voxel_y;
      logic [5:0]         voxel_z;
      logic [15:0]        material_key;
      logic signed [31:0] origin_x;
      logic signed [31:0] origin_y;
      logic signed [31:0] origin_z;
      logic signed [31:0] direction_x;
      logic signed [31:0] direction_y;
      logic signed [31:0] direction_z;
      logic signed [31:0] max_distance;
   } req_type;

   typedef struct packed {
      logic               hit;
      logic signed [31:0] hit_distance;
      logic [15:0]        voxel_key;
      logic [1:0]         hit_axis;
      logic               started_inside;
   } rsp_type;

   typedef struct packed {
      logic     start;
      logic     is_div;
      wide_type a;
      wide_type b;
   } md_req_type;

   typedef struct packed {
      logic     busy;
      logic     done;
      wide_type result;
   } md_sts_type;

   function automatic wide_type sext32(input logic signed [31:0] v);
      return {{32{v[31]}}, v};
   endfunction

   // floor of v / 2^24
   function automatic wide_type shr24(input wide_type v);
      return v >>> FRAC_BITS;
   endfunction

   // ceiling of v / 2^24
   function automatic wide_type ceil24(input wide_type v);
      return -((-v) >>> FRAC_BITS);
   endfunction

   function automatic logic [31:0] sat32(input wide_type v);
      if (v > 64'sd2147483647) begin
         return 32'h7FFF_FFFF;
      end
      if (v < -64'sd2147483648) begin
         return 32'h8000_0000;
      end
      return v[31:0];
   endfunction

endpackage
`default_nettype wire

// ----- sv/vgrt_voxel_ram.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// vgrt_voxel_ram
// Single-port-write, registered-read voxel key store with a zeroing sweep
// after reset.
// ---------------------------------------------------------------------------
module vgrt_voxel_ram #(
   parameter int DEPTH  = 262144,
   parameter int ADDR_W = 18
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              wr_en,
   input  wire logic [ADDR_W-1:0] wr_addr,
   input  wire logic [15:0]       wr_data,
   input  wire logic [ADDR_W-1:0] rd_addr,
   output logic [15:0]            rd_data,
   output logic                   ready
);

   logic [15:0]       mem [DEPTH];
   logic              clr_ff;
   logic [ADDR_W-1:0] clr_addr_ff;
   logic [15:0]       rd_data_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         clr_ff      <= 1'b1;
         clr_addr_ff <= '0;
      end else if (clr_ff) begin
         clr_addr_ff <= clr_addr_ff + 1'b1;
         if (clr_addr_ff == ADDR_W'(DEPTH - 1)) begin
            clr_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (clr_ff) begin
         mem[clr_addr_ff] <= 16'd0;
      end else if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;
   assign ready   = !clr_ff;

endmodule
`default_nettype wire

// ----- sv/vgrt_muldiv.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// vgrt_muldiv
// Shared bit-serial unit: 64x32 signed multiply (32 steps, low 64 bits kept)
// and 64-bit signed divide truncating toward zero (64 steps).
// ---------------------------------------------------------------------------
module vgrt_muldiv (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire vgrt_pkg::md_req_type md_req,
   output vgrt_pkg::md_sts_type      md_sts
);
   import vgrt_pkg::*;

   logic       busy_ff;
   logic       done_ff;
   logic       is_div_ff;
   logic       neg_ff;
   logic [5:0] cnt_ff;
   logic [63:0] acc_ff;
   logic [63:0] x_ff;
   logic [63:0] y_ff;

   logic [64:0] rem_sh;
   logic [64:0] rem_sub;
   logic        fits;
   logic        last;
   logic [63:0] addend;
   logic [63:0] abs_a;
   logic [63:0] abs_b;

   always_comb begin
      rem_sh  = {acc_ff, x_ff[63]};
      fits    = rem_sh >= {1'b0, y_ff};
      rem_sub = rem_sh - {1'b0, y_ff};
      last    = is_div_ff ? (cnt_ff == 6'd63) : (cnt_ff == 6'd31);
      // top multiplier bit carries negative weight
      addend  = (cnt_ff == 6'd31) ? (~x_ff + 64'd1) : x_ff;
      abs_a   = md_req.a[63] ? (~md_req.a + 64'd1) : md_req.a;
      abs_b   = md_req.b[63] ? (~md_req.b + 64'd1) : md_req.b;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         done_ff <= 1'b0;
         if (md_req.start) begin
            busy_ff   <= 1'b1;
            cnt_ff    <= 6'd0;
            is_div_ff <= md_req.is_div;
            acc_ff    <= 64'd0;
            if (md_req.is_div) begin
               x_ff   <= abs_a;
               y_ff   <= abs_b;
               neg_ff <= md_req.a[63] ^ md_req.b[63];
            end else begin
               x_ff   <= md_req.a;
               y_ff   <= {32'd0, md_req.b[31:0]};
               neg_ff <= 1'b0;
            end
         end else if (busy_ff) begin
            cnt_ff <= cnt_ff + 6'd1;
            if (is_div_ff) begin
               acc_ff <= fits ? rem_sub[63:0] : rem_sh[63:0];
               x_ff   <= {x_ff[62:0], fits};
            end else begin
               if (y_ff[0]) begin
                  acc_ff <= acc_ff + addend;
               end
               x_ff <= {x_ff[62:0], 1'b0};
               y_ff <= {1'b0, y_ff[63:1]};
            end
            if (last) begin
               busy_ff <= 1'b0;
               done_ff <= 1'b1;
            end
         end
      end
   end

   always_comb begin
      md_sts.busy   = busy_ff;
      md_sts.done   = done_ff;
      md_sts.result = is_div_ff ? (neg_ff ? -signed'(x_ff) : signed'(x_ff))
                                : signed'(acc_ff);
   end

endmodule
`default_nettype wire

// ----- sv/voxel_grid_ray_traversal_core.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// voxel_grid_ray_traversal_core
// Voxel grid store with 3D DDA ray walk for nearest-hit and occlusion queries.
// ---------------------------------------------------------------------------
// A ray runs alone: an origin nudge step, then for an origin outside the cube
// up to six slab divisions, then per axis one multiply and two divisions,
// all on the one shared bit-serial multiply/divide unit. An axis with a zero
// direction skips its divisions. The walk visits each voxel in a read state
// and then an evaluate state, as the voxel memory read is registered. After
// reset the memory is zeroed by a sweep over all GRID_SIDE^3 cells (262144 at
// the default) during which no request is taken.
// ---------------------------------------------------------------------------
module voxel_grid_ray_traversal_core #(
   parameter int GRID_SIDE = 64
) (
   input  wire logic              clock,
   input  wire logic              reset,
   input  wire logic              req_valid,
   output logic                   req_stall,
   input  wire vgrt_pkg::req_type req_data,
   output logic                   rsp_valid,
   input  wire logic              rsp_stall,
   output vgrt_pkg::rsp_type      rsp_data
);
   import vgrt_pkg::*;

   localparam int       CW     = (GRID_SIDE > 1) ? $clog2(GRID_SIDE) : 1;
   localparam int       DEPTH  = GRID_SIDE * GRID_SIDE * GRID_SIDE;
   localparam int       ADDR_W = $clog2(DEPTH);
   localparam wide_type G_W    = wide_type'(GRID_SIDE);
   localparam logic [CW-1:0] C_LAST = CW'(GRID_SIDE - 1);

   typedef enum logic [3:0] {
      ST_IDLE, ST_NUDGE, ST_CLIP_A, ST_CLIP_W1, ST_CLIP_W2, ST_CLIP_MERGE,
      ST_SET_MUL, ST_SET_MW, ST_SET_POS, ST_SET_NUM, ST_SET_W1, ST_SET_W2,
      ST_WALK_RD, ST_WALK_EV, ST_FIN
   } state_type;

   state_type          state_ff;
   logic [1:0]         ax_ff;
   logic [1:0]         func_ff;
   wide_type           o_ff [3];
   logic signed [31:0] d_ff [3];
   wide_type           lo_ff [3];
   wide_type           hi_ff [3];
   wide_type           tm_ff [3];
   wide_type           td_ff [3];
   logic [CW-1:0]      c_ff [3];
   logic               neg_ff [3];
   wide_type           t_ff;
   wide_type           limit_ff;
   wide_type           t1_ff;
   wide_type           p0_ff;
   wide_type           pg_ff;
   logic               in_cube_ff;
   logic               inside_ff;
   logic               first_ff;
   logic [1:0]         axis_ff;
   logic [1:0]         pa_ff;
   logic [15:0]        key_ff;
   rsp_type            res_ff;
   rsp_type            rsp_data_ff;
   logic               rsp_valid_ff;

   md_req_type md_req;
   md_sts_type md_sts;

   logic              req_accept;
   logic              in_grid;
   logic              mem_wr_en;
   logic [31:0]       wr32;
   logic [31:0]       rd32;
   logic [15:0]       mem_rd_data;
   logic              mem_ready;

   wide_type o_nudged [3];
   logic     cube;
   wide_type d_cur;
   wide_type o_cur;
   wide_type gd_cur;
   wide_type gd_abs;
   logic     d_zero;
   logic     ok_cur;
   wide_type pg_val;
   wide_type f_val;
   logic [CW-1:0] c_clamp;
   wide_type num_val;
   wide_type tmin;
   wide_type tmax;
   logic [1:0] clip_axis;
   logic [1:0] pick;
   logic       kz;
   logic       ins;
   logic       step_out;
   logic [CW-1:0] c_step;
   logic [15:0]   key_n;
   rsp_type miss_rsp;
   rsp_type occ_rsp;

   // ---------------------------------------------------------------------
   // handshake and memory addressing
   // ---------------------------------------------------------------------
   assign req_stall  = (state_ff != ST_IDLE) || !mem_ready;
   assign req_accept = req_valid && !req_stall;
   assign in_grid    = (32'(req_data.voxel_x) < 32'(GRID_SIDE))
                    && (32'(req_data.voxel_y) < 32'(GRID_SIDE))
                    && (32'(req_data.voxel_z) < 32'(GRID_SIDE));
   assign mem_wr_en  = req_accept && (req_data.func == FUNC_WRITE) && in_grid;
   assign wr32 = 32'(req_data.voxel_x) + 32'(req_data.voxel_y) * 32'(GRID_SIDE)
               + 32'(req_data.voxel_z) * 32'(GRID_SIDE * GRID_SIDE);
   assign rd32 = 32'(c_ff[0]) + 32'(c_ff[1]) * 32'(GRID_SIDE)
               + 32'(c_ff[2]) * 32'(GRID_SIDE * GRID_SIDE);

   vgrt_voxel_ram #(
      .DEPTH  (DEPTH),
      .ADDR_W (ADDR_W)
   ) u_ram (
      .clock   (clock),
      .reset   (reset),
      .wr_en   (mem_wr_en),
      .wr_addr (wr32[ADDR_W-1:0]),
      .wr_data (req_data.material_key),
      .rd_addr (rd32[ADDR_W-1:0]),
      .rd_data (mem_rd_data),
      .ready   (mem_ready)
   );

   vgrt_muldiv u_muldiv (
      .clock  (clock),
      .reset  (reset),
      .md_req (md_req),
      .md_sts (md_sts)
   );

   // ---------------------------------------------------------------------
   // datapath helpers
   // ---------------------------------------------------------------------
   always_comb begin
      cube = 1'b1;
      for (int i = 0; i < 3; i++) begin
         o_nudged[i] = o_ff[i] + shr24(sext32(d_ff[i]) * RAY_NUDGE);
         if (o_nudged[i] < 0 || o_nudged[i] > ONE_Q) begin
            cube = 1'b0;
         end
      end

      d_cur  = sext32(d_ff[ax_ff]);
      o_cur  = o_ff[ax_ff];
      gd_cur = d_cur * G_W;
      gd_abs = (gd_cur < 0) ? -gd_cur : gd_cur;
      d_zero = (d_ff[ax_ff] == 32'sd0);
      ok_cur = (o_cur >= 0) && (o_cur <= ONE_Q);

      pg_val = G_W * (p0_ff + shr24(d_cur * SETUP_NUDGE));
      f_val  = shr24(pg_val);
      if (f_val < 0) begin
         c_clamp = '0;
      end else if (f_val > G_W - 64'sd1) begin
         c_clamp = C_LAST;
      end else begin
         c_clamp = f_val[CW-1:0];
      end
      // distance to the first boundary, scaled by grid side and 2^24
      num_val = (((ceil24(pg_ff) - (neg_ff[ax_ff] ? 64'sd1 : 64'sd0))
                 <<< FRAC_BITS) - G_W * p0_ff) <<< FRAC_BITS;

      tmin = lo_ff[0];
      if (lo_ff[1] > tmin) tmin = lo_ff[1];
      if (lo_ff[2] > tmin) tmin = lo_ff[2];
      tmax = hi_ff[0];
      if (hi_ff[1] < tmax) tmax = hi_ff[1];
      if (hi_ff[2] < tmax) tmax = hi_ff[2];
      if (tmin == lo_ff[2]) begin
         clip_axis = AXIS_Z;
      end else if (tmin == lo_ff[1]) begin
         clip_axis = AXIS_Y;
      end else begin
         clip_axis = AXIS_X;
      end

      if (tm_ff[0] < tm_ff[1]) begin
         pick = (tm_ff[0] < tm_ff[2]) ? AXIS_X : AXIS_Z;
      end else begin
         pick = (tm_ff[1] < tm_ff[2]) ? AXIS_Y : AXIS_Z;
      end

      kz       = (mem_rd_data == 16'd0);
      ins      = first_ff ? (in_cube_ff && !kz) : inside_ff;
      key_n    = ins ? mem_rd_data : key_ff;
      step_out = neg_ff[pa_ff] ? (c_ff[pa_ff] == '0) : (c_ff[pa_ff] == C_LAST);
      c_step   = neg_ff[pa_ff] ? (c_ff[pa_ff] - CW'(1)) : (c_ff[pa_ff] + CW'(1));

      miss_rsp.hit            = 1'b0;
      miss_rsp.hit_distance   = MISS_DIST;
      miss_rsp.voxel_key      = 16'd0;
      miss_rsp.hit_axis       = AXIS_X;
      miss_rsp.started_inside = 1'b0;
      occ_rsp     = miss_rsp;
      occ_rsp.hit = 1'b1;
   end

   function automatic rsp_type near_rsp(input logic [15:0] key, input wide_type t,
                                        input logic [1:0] axis, input logic ins_flag);
      rsp_type r;
      r.hit            = (key != 16'd0);
      r.hit_distance   = sat32(t);
      r.voxel_key      = key;
      r.hit_axis       = axis;
      r.started_inside = ins_flag;
      return r;
   endfunction

   // requests to the shared multiply/divide unit
   always_comb begin
      md_req = '0;
      case (state_ff)
         ST_CLIP_A: begin
            md_req.start  = !d_zero;
            md_req.is_div = 1'b1;
            md_req.a      = (-o_cur) <<< FRAC_BITS;
            md_req.b      = d_cur;
         end
         ST_CLIP_W1: begin
            md_req.start  = md_sts.done;
            md_req.is_div = 1'b1;
            md_req.a      = (ONE_Q - o_cur) <<< FRAC_BITS;
            md_req.b      = d_cur;
         end
         ST_SET_MUL: begin
            md_req.start  = 1'b1;
            md_req.is_div = 1'b0;
            md_req.a      = t_ff;
            md_req.b      = d_cur;
         end
         ST_SET_NUM: begin
            md_req.start  = 1'b1;
            md_req.is_div = 1'b1;
            md_req.a      = num_val;
            md_req.b      = gd_cur;
         end
         ST_SET_W1: begin
            md_req.start  = md_sts.done;
            md_req.is_div = 1'b1;
            md_req.a      = TD_NUM;
            md_req.b      = gd_abs;
         end
         default: begin
            md_req = '0;
         end
      endcase
   end

   // ---------------------------------------------------------------------
   // sequencer
   // ---------------------------------------------------------------------
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (rsp_valid_ff && !rsp_stall && (state_ff != ST_FIN)) begin
            rsp_valid_ff <= 1'b0;
         end
         case (state_ff)
            ST_IDLE: begin
               if (req_accept && (req_data.func == FUNC_NEAREST
                                  || req_data.func == FUNC_OCCLUDE)) begin
                  func_ff  <= req_data.func;
                  o_ff[0]  <= sext32(req_data.origin_x);
                  o_ff[1]  <= sext32(req_data.origin_y);
                  o_ff[2]  <= sext32(req_data.origin_z);
                  d_ff[0]  <= req_data.direction_x;
                  d_ff[1]  <= req_data.direction_y;
                  d_ff[2]  <= req_data.direction_z;
                  limit_ff <= sext32(req_data.max_distance) - (RAY_NUDGE <<< 1);
                  state_ff <= ST_NUDGE;
               end
            end
            ST_NUDGE: begin
               for (int i = 0; i < 3; i++) begin
                  o_ff[i] <= o_nudged[i];
               end
               in_cube_ff <= cube;
               ax_ff      <= AXIS_X;
               if (cube) begin
                  t_ff     <= '0;
                  axis_ff  <= AXIS_X;
                  state_ff <= ST_SET_MUL;
               end else begin
                  state_ff <= ST_CLIP_A;
               end
            end
            ST_CLIP_A: begin
               if (d_zero) begin
                  lo_ff[ax_ff] <= ok_cur ? -T_INF : T_INF;
                  hi_ff[ax_ff] <= ok_cur ? T_INF : -T_INF;
                  if (ax_ff == AXIS_Z) begin
                     state_ff <= ST_CLIP_MERGE;
                  end else begin
                     ax_ff <= ax_ff + 2'd1;
                  end
               end else begin
                  state_ff <= ST_CLIP_W1;
               end
            end
            ST_CLIP_W1: begin
               if (md_sts.done) begin
                  t1_ff    <= md_sts.result;
                  state_ff <= ST_CLIP_W2;
               end
            end
            ST_CLIP_W2: begin
               if (md_sts.done) begin
                  if (t1_ff < md_sts.result) begin
                     lo_ff[ax_ff] <= t1_ff;
                     hi_ff[ax_ff] <= md_sts.result;
                  end else begin
                     lo_ff[ax_ff] <= md_sts.result;
                     hi_ff[ax_ff] <= t1_ff;
                  end
                  if (ax_ff == AXIS_Z) begin
                     state_ff <= ST_CLIP_MERGE;
                  end else begin
                     ax_ff    <= ax_ff + 2'd1;
                     state_ff <= ST_CLIP_A;
                  end
               end
            end
            ST_CLIP_MERGE: begin
               if (tmax < tmin || tmax < 0) begin
                  res_ff   <= miss_rsp;
                  state_ff <= ST_FIN;
               end else begin
                  t_ff     <= tmin;
                  axis_ff  <= clip_axis;
                  ax_ff    <= AXIS_X;
                  state_ff <= ST_SET_MUL;
               end
            end
            ST_SET_MUL: begin
               state_ff <= ST_SET_MW;
            end
            ST_SET_MW: begin
               if (md_sts.done) begin
                  p0_ff    <= o_cur + shr24(md_sts.result);
                  state_ff <= ST_SET_POS;
               end
            end
            ST_SET_POS: begin
               pg_ff         <= pg_val;
               c_ff[ax_ff]   <= c_clamp;
               neg_ff[ax_ff] <= (d_cur < 0);
               if (d_zero) begin
                  tm_ff[ax_ff] <= T_INF;
                  td_ff[ax_ff] <= '0;
                  if (ax_ff == AXIS_Z) begin
                     first_ff <= 1'b1;
                     key_ff   <= 16'd0;
                     state_ff <= ST_WALK_RD;
                  end else begin
                     ax_ff    <= ax_ff + 2'd1;
                     state_ff <= ST_SET_MUL;
                  end
               end else begin
                  state_ff <= ST_SET_NUM;
               end
            end
            ST_SET_NUM: begin
               state_ff <= ST_SET_W1;
            end
            ST_SET_W1: begin
               if (md_sts.done) begin
                  tm_ff[ax_ff] <= t_ff + md_sts.result;
                  state_ff     <= ST_SET_W2;
               end
            end
            ST_SET_W2: begin
               if (md_sts.done) begin
                  td_ff[ax_ff] <= md_sts.result;
                  if (ax_ff == AXIS_Z) begin
                     first_ff <= 1'b1;
                     key_ff   <= 16'd0;
                     state_ff <= ST_WALK_RD;
                  end else begin
                     ax_ff    <= ax_ff + 2'd1;
                     state_ff <= ST_SET_MUL;
                  end
               end
            end
            ST_WALK_RD: begin
               pa_ff <= pick;
               if (func_ff == FUNC_OCCLUDE && !(t_ff < limit_ff)) begin
                  res_ff   <= miss_rsp;
                  state_ff <= ST_FIN;
               end else begin
                  state_ff <= ST_WALK_EV;
               end
            end
            ST_WALK_EV: begin
               first_ff <= 1'b0;
               if (func_ff == FUNC_OCCLUDE) begin
                  if (!kz) begin
                     res_ff   <= occ_rsp;
                     state_ff <= ST_FIN;
                  end else if (step_out) begin
                     res_ff   <= miss_rsp;
                     state_ff <= ST_FIN;
                  end else begin
                     c_ff[pa_ff]  <= c_step;
                     t_ff         <= tm_ff[pa_ff];
                     tm_ff[pa_ff] <= tm_ff[pa_ff] + td_ff[pa_ff];
                     state_ff     <= ST_WALK_RD;
                  end
               end else begin
                  inside_ff <= ins;
                  if (ins ? kz : !kz) begin
                     // solid cell found, or the solid run the ray started in ends
                     res_ff   <= near_rsp(ins ? key_ff : mem_rd_data, t_ff, axis_ff, ins);
                     state_ff <= ST_FIN;
                  end else begin
                     key_ff  <= key_n;
                     t_ff    <= tm_ff[pa_ff];
                     axis_ff <= pa_ff;
                     if (step_out) begin
                        res_ff   <= near_rsp(key_n, tm_ff[pa_ff], pa_ff, ins);
                        state_ff <= ST_FIN;
                     end else begin
                        c_ff[pa_ff]  <= c_step;
                        tm_ff[pa_ff] <= tm_ff[pa_ff] + td_ff[pa_ff];
                        state_ff     <= ST_WALK_RD;
                     end
                  end
               end
            end
            ST_FIN: begin
               if (!rsp_valid_ff || !rsp_stall) begin
                  rsp_valid_ff <= 1'b1;
                  rsp_data_ff  <= res_ff;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // ---------------------------------------------------------------------
   // assertions
   // ---------------------------------------------------------------------
   a_clear_blocks_req: assert property (@(posedge clock) disable iff (reset)
      !mem_ready |-> req_stall)
      else $error("request taken during memory clear");

   a_md_start_idle: assert property (@(posedge clock) disable iff (reset)
      md_req.start |-> !md_sts.busy)
      else $error("muldiv started while busy");

   a_rsp_from_fin: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> $past(state_ff == ST_FIN))
      else $error("result presented outside finish state");

   a_write_when_idle: assert property (@(posedge clock) disable iff (reset)
      mem_wr_en |-> (state_ff == ST_IDLE))
      else $error("voxel write during a ray");

   a_cell_in_grid: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_WALK_EV) |->
         (c_ff[0] <= C_LAST) && (c_ff[1] <= C_LAST) && (c_ff[2] <= C_LAST))
      else $error("walk cell index out of grid");

endmodule
`default_nettype wire

// ----- tb/testbench.sv -----
`default_nettype none
// ---------------------------------------------------------------------------
// testbench
// Checks the voxel ray core against its own predictor of the grid and DDA
// walk: directed writes and rays, a random scene with randomized idling, and
// a long result hold-off that backs the block up.
// ---------------------------------------------------------------------------
module testbench;
   import vgrt_pkg::*;

   localparam int SIDE = 64;
   localparam longint Q1 = 64'sd16777216;
   localparam longint TBIG = 64'sh4000_0000_0000_0000;
   localparam int CYCLE_LIMIT = 14000000;
   localparam int HOLD_CYCLES = 6000;
   localparam logic [1:0] FUNC_UNUSED = 2'd3;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic req_valid = 1'b0;
   logic req_stall;
   req_type req_data = '0;
   logic rsp_valid;
   logic rsp_stall = 1'b0;
   rsp_type rsp_data;

   logic [15:0] grid_model [SIDE*SIDE*SIDE];
   rsp_type pending_rsp [$];
   bit failed = 1'b0;
   bit hold_request = 1'b0;
   int cycle_count = 0;

   voxel_grid_ray_traversal_core #(.GRID_SIDE(SIDE)) dut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_data(req_data),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_data(rsp_data)
   );

   always #10 clock = ~clock;

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count > CYCLE_LIMIT) begin
         $display("Regression FAIL");
         $finish;
      end
   end

   function automatic logic [15:0] grid_at(input longint cx, input longint cy,
                                           input longint cz);
      return grid_model[cx + cy*SIDE + cz*SIDE*SIDE];
   endfunction

   function automatic logic [31:0] clamp32(input longint v);
      if (v > 64'sd2147483647) return 32'h7FFF_FFFF;
      if (v < -64'sd2147483648) return 32'h8000_0000;
      return v[31:0];
   endfunction

   function automatic int min_axis(input longint m0, input longint m1, input longint m2);
      if (m0 < m1) return (m0 < m2) ? 0 : 2;
      return (m1 < m2) ? 1 : 2;
   endfunction

   // walks the grid model for one ray
   function automatic rsp_type trace_ray(input req_type q);
      longint o[3], d[3], tm[3], td[3], st[3], c[3], lo[3], hi[3];
      longint t, tmin, tmax, limit, p0, pg, f, up, sgn, gd, t1, t2;
      logic signed [31:0] oin[3], din[3];
      int a, axis;
      bit in_cube, start_solid;
      logic [15:0] key, k;
      rsp_type r;
      r = '0;
      r.hit_distance = MISS_DIST;
      t = 0;
      axis = 0;
      key = '0;
      in_cube = 1'b1;
      oin[0] = q.origin_x; oin[1] = q.origin_y; oin[2] = q.origin_z;
      din[0] = q.direction_x; din[1] = q.direction_y; din[2] = q.direction_z;
      for (int i = 0; i < 3; i++) begin
         d[i] = din[i];
         o[i] = longint'(oin[i]) + ((longint'(1678) * d[i]) >>> 24);
         if (o[i] < 0 || o[i] > Q1) in_cube = 1'b0;
      end
      limit = longint'(q.max_distance) - 2*1678;
      if (!in_cube) begin
         for (int i = 0; i < 3; i++) begin
            if (d[i] == 0) begin
               if (o[i] >= 0 && o[i] <= Q1) begin
                  lo[i] = -TBIG; hi[i] = TBIG;
               end else begin
                  lo[i] = TBIG; hi[i] = -TBIG;
               end
            end else begin
               t1 = (-o[i]) * Q1 / d[i];
               t2 = (Q1 - o[i]) * Q1 / d[i];
               lo[i] = (t1 < t2) ? t1 : t2;
               hi[i] = (t1 < t2) ? t2 : t1;
            end
         end
         tmin = lo[0]; tmax = hi[0];
         for (int i = 1; i < 3; i++) begin
            if (lo[i] > tmin) tmin = lo[i];
            if (hi[i] < tmax) tmax = hi[i];
         end
         if (tmin == lo[2]) axis = 2;
         else if (tmin == lo[1]) axis = 1;
         if (tmax < tmin || tmax < 0) return r;
         t = tmin;
      end
      for (int i = 0; i < 3; i++) begin
         p0 = o[i] + ((t * d[i]) >>> 24);
         pg = SIDE * (p0 + ((longint'(839) * d[i]) >>> 24));
         f = pg >>> 24;
         up = -((-pg) >>> 24);
         sgn = (d[i] < 0) ? 1 : 0;
         c[i] = (f < 0) ? 0 : ((f > SIDE-1) ? SIDE-1 : f);
         st[i] = 1 - 2*sgn;
         if (d[i] == 0) begin
            tm[i] = TBIG; td[i] = 0;
         end else begin
            gd = SIDE * d[i];
            tm[i] = t + ((up - sgn) * Q1 - SIDE * p0) * Q1 / gd;
            td[i] = Q1 * Q1 / ((gd < 0) ? -gd : gd);
         end
      end
      start_solid = in_cube && grid_at(c[0], c[1], c[2]) != 0;

      if (q.func == FUNC_OCCLUDE) begin
         while (t < limit) begin
            if (grid_at(c[0], c[1], c[2]) != 0) begin
               r.hit = 1'b1;
               return r;
            end
            a = min_axis(tm[0], tm[1], tm[2]);
            c[a] += st[a];
            if (c[a] < 0 || c[a] >= SIDE) break;
            t = tm[a];
            tm[a] += td[a];
         end
         return r;
      end

      forever begin
         k = grid_at(c[0], c[1], c[2]);
         if (start_solid ? (k == 0) : (k != 0)) begin
            if (!start_solid) key = k;
            break;
         end
         if (start_solid) key = k;
         a = min_axis(tm[0], tm[1], tm[2]);
         t = tm[a];
         c[a] += st[a];
         axis = a;
         if (c[a] < 0 || c[a] >= SIDE) break;
         tm[a] += td[a];
      end
      r.hit = (key != 0);
      r.hit_distance = clamp32(t);
      r.voxel_key = key;
      r.hit_axis = axis[1:0];
      r.started_inside = start_solid;
      return r;
   endfunction

   // one transfer on the request side, then an optional gap
   task automatic send_item(input req_type q);
      int gap;
      @(negedge clock);
      req_valid = 1'b1;
      req_data = q;
      forever begin
         @(posedge clock);
         if (!req_stall) break;
      end
      case (q.func)
         FUNC_WRITE: begin
            grid_model[q.voxel_x + q.voxel_y*SIDE + q.voxel_z*SIDE*SIDE] = q.material_key;
         end
         FUNC_NEAREST, FUNC_OCCLUDE: begin
            pending_rsp.insert(pending_rsp.size(), trace_ray(q));
         end
         default: ;
      endcase
      gap = ($urandom_range(0, 2) == 0) ? 0 :
            (($urandom_range(0, 19) == 0) ? $urandom_range(20, 200) : $urandom_range(1, 4));
      if (gap > 0) begin
         @(negedge clock);
         req_valid = 1'b0;
         repeat (gap - 1) @(negedge clock);
      end
   endtask

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_rsp.size() == 0) begin
            $error("result with none expected");
            failed = 1'b1;
         end else begin
            rsp_type e;
            e = pending_rsp.pop_front();
            if (rsp_data.hit !== e.hit) begin
               $error("hit: expected %0d actual %0d", e.hit, rsp_data.hit);
               failed = 1'b1;
            end
            if (rsp_data.hit_distance !== e.hit_distance) begin
               $error("hit_distance: expected %h actual %h", e.hit_distance,
                      rsp_data.hit_distance);
               failed = 1'b1;
            end
            if (rsp_data.voxel_key !== e.voxel_key) begin
               $error("voxel_key: expected %h actual %h", e.voxel_key, rsp_data.voxel_key);
               failed = 1'b1;
            end
            if (rsp_data.hit_axis !== e.hit_axis) begin
               $error("hit_axis: expected %0d actual %0d", e.hit_axis, rsp_data.hit_axis);
               failed = 1'b1;
            end
            if (rsp_data.started_inside !== e.started_inside) begin
               $error("started_inside: expected %0d actual %0d", e.started_inside,
                      rsp_data.started_inside);
               failed = 1'b1;
            end
         end
      end
   end

   // result side idling, plus the long hold-off on request
   initial begin
      int n;
      forever begin
         @(negedge clock);
         if (hold_request) begin
            rsp_stall = 1'b1;
            repeat (HOLD_CYCLES) @(negedge clock);
            hold_request = 1'b0;
            rsp_stall = 1'b0;
         end else if ($urandom_range(0, 2) == 0) begin
            rsp_stall = 1'b1;
            n = ($urandom_range(0, 14) == 0) ? $urandom_range(20, 150) : $urandom_range(1, 4);
            repeat (n - 1) @(negedge clock);
         end else begin
            rsp_stall = 1'b0;
            repeat ($urandom_range(0, 30)) @(negedge clock);
         end
      end
   end

   function automatic int span(input int lo, input int hi);
      return lo + int'($urandom_range(0, hi - lo));
   endfunction

   function automatic req_type make_write(input int x, input int y, input int z,
                                          input logic [15:0] key);
      req_type q;
      q = {4'($urandom), $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
           $urandom, $urandom};
      q.func = FUNC_WRITE;
      q.voxel_x = 6'(x); q.voxel_y = 6'(y); q.voxel_z = 6'(z);
      q.material_key = key;
      return q;
   endfunction

   function automatic req_type make_ray(input logic [1:0] fn,
                                        input int ox, input int oy, input int oz,
                                        input int dx, input int dy, input int dz,
                                        input int maxd);
      req_type q;
      q = {4'($urandom), $urandom, $urandom, $urandom, $urandom, $urandom, $urandom,
           $urandom, $urandom};
      q.func = fn;
      q.origin_x = ox; q.origin_y = oy; q.origin_z = oz;
      q.direction_x = dx; q.direction_y = dy; q.direction_z = dz;
      q.max_distance = maxd;
      return q;
   endfunction

   function automatic int rand_origin();
      case ($urandom_range(0, 9))
         0: return span(-33554432, -1);
         1: return span(16777217, 50331648);
         2: return $urandom;
         default: return span(0, 16777216);
      endcase
   endfunction

   function automatic int rand_dir();
      case ($urandom_range(0, 19))
         0, 1: return 0;
         2: return $urandom;
         3: return span(-300, 300);
         default: return span(-16777216, 16777216);
      endcase
   endfunction

   task automatic test_directed();
      int h;
      h = 16777216 / 2;
      send_item(make_write(0, 0, 0, 16'hFFFF));
      send_item(make_write(63, 63, 63, 16'h0001));
      send_item(make_write(32, 32, 32, 16'h1234));
      send_item(make_write(40, 32, 32, 16'h8000));
      send_item(make_ray(FUNC_UNUSED, h, h, h, 16777216, 0, 0, 0));
      // from center along +x: starts inside solid, finds exit
      send_item(make_ray(FUNC_NEAREST, h + 4000, h + 4000, h + 4000, 16777216, 0, 0, 0));
      // from left of the center voxel: hits it
      send_item(make_ray(FUNC_NEAREST, 100000, h + 4000, h + 4000, 16777216, 0, 0, 0));
      // clipped from outside the cube
      send_item(make_ray(FUNC_NEAREST, -16777216, h + 4000, h + 4000, 16777216, 0, 0, 0));
      // misses the cube
      send_item(make_ray(FUNC_NEAREST, -16777216, 2*16777216, h, 16777216, 0, 0, 0));
      send_item(make_ray(FUNC_NEAREST, -16777216, h, h, -16777216, 0, 0, 0));
      // corner voxels along the diagonal
      send_item(make_ray(FUNC_NEAREST, 16777216, 16777216, 16777216,
                         -9686330, -9686330, -9686330, 0));
      send_item(make_ray(FUNC_NEAREST, 1000, 1000, 1000, 9686330, 9686330, 9686330, 0));
      send_item(make_ray(FUNC_NEAREST, h, h, h, 0, 0, 0, 0));
      send_item(make_ray(FUNC_OCCLUDE, 100000, h + 4000, h + 4000, 16777216, 0, 0, 16777216));
      send_item(make_ray(FUNC_OCCLUDE, 100000, h + 4000, h + 4000, 16777216, 0, 0, 10000));
      send_item(make_ray(FUNC_OCCLUDE, 100000, h + 4000, h + 4000, 16777216, 0, 0,
                         32'sh8000_0000));
      send_item(make_ray(FUNC_OCCLUDE, 100000, 100000, h, 0, 16777216, 0, 32'sh7FFF_FFFF));
      send_item(make_ray(FUNC_NEAREST, 32'sh7FFF_FFFF, 32'sh8000_0000, 32'sh7FFF_FFFF,
                         32'sh8000_0000, 32'sh7FFF_FFFF, 32'sh8000_0000, 0));
      send_item(make_ray(FUNC_NEAREST, 32'sh8000_0000, h, h, 32'sh7FFF_FFFF, 1, -1, 0));
      send_item(make_write(32, 32, 32, 16'h0000));
      send_item(make_ray(FUNC_NEAREST, 100000, h + 4000, h + 4000, 16777216, 0, 0, 0));
   endtask

   task automatic test_random_scene(input int count);
      int x, y, z;
      req_type q;
      for (int n = 0; n < count; n++) begin
         case ($urandom_range(0, 19))
            0, 1, 2, 3, 4, 5, 6: begin
               // clustered near the center so rays meet solid voxels
               x = span(20, 43); y = span(20, 43); z = span(20, 43);
               if ($urandom_range(0, 9) == 0) begin
                  x = $urandom_range(0, 63); y = $urandom_range(0, 63);
                  z = $urandom_range(0, 63);
               end
               send_item(make_write(x, y, z,
                  ($urandom_range(0, 5) == 0) ? 16'h0000 : 16'($urandom)));
            end
            7: begin
               q = {4'($urandom), $urandom, $urandom, $urandom, $urandom, $urandom,
                    $urandom, $urandom, $urandom};
               q.func = ($urandom_range(0, 1) == 0) ? FUNC_UNUSED : FUNC_NEAREST;
               send_item(q);
            end
            default: begin
               send_item(make_ray(($urandom_range(0, 2) == 0) ? FUNC_OCCLUDE : FUNC_NEAREST,
                  rand_origin(), rand_origin(), rand_origin(),
                  rand_dir(), rand_dir(), rand_dir(),
                  ($urandom_range(0, 7) == 0) ? int'($urandom) : span(-1000, 33554432)));
            end
         endcase
      end
   endtask

   task automatic test_result_holdoff();
      int h;
      h = 16777216 / 2;
      // the last request must not be offered again while the queue drains
      @(negedge clock);
      req_valid = 1'b0;
      wait (pending_rsp.size() == 0);
      hold_request = 1'b1;
      for (int n = 0; n < 12; n++) begin
         send_item(make_ray(FUNC_NEAREST, span(0, 500000), h + span(-4000000, 4000000),
                            h + span(-4000000, 4000000), 16777216,
                            span(-1000000, 1000000), span(-1000000, 1000000), 0));
      end
   endtask

   initial begin
      foreach (grid_model[i]) grid_model[i] = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;
      test_directed();
      test_random_scene(600);
      test_result_holdoff();
      test_random_scene(700);
      @(negedge clock);
      req_valid = 1'b0;
      wait (pending_rsp.size() == 0);
      repeat (3000) @(posedge clock);
      if (!failed && pending_rsp.size() == 0) begin
         $display("Regression PASS");
      end else begin
         $display("Regression FAIL");
      end
      $finish;
   end

endmodule
`default_nettype wire
